// File: rtl/core/crs_pkg.sv
// Shared types and constants of the constraint row impulse solver.
// Used by the controller, the datapath and the top level; no dependencies.
package crs_pkg;

  localparam int unsigned BODY_COUNT_DEF = 64;
  localparam int unsigned IDX_RAW_W      = 6;
  localparam int unsigned VEC_W          = 63;
  localparam int unsigned COMP_W         = 21;
  localparam int unsigned SCL_W          = 32;
  localparam int unsigned ACC_W          = 46;
  localparam int unsigned MUL_W          = 33;
  localparam int unsigned PROD_W         = 66;
  localparam int unsigned DIV_W          = 49;
  localparam int unsigned DIV_CNT_W      = 6;
  localparam int unsigned STEP_W         = 6;

  // Function codes
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_BOTH  = 2'd1;
  localparam logic [1:0] FUNC_LOWER = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_JAC_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

  // Datapath micro-operations
  typedef enum logic [3:0] {
    OP_NONE, OP_DOT, OP_APC, OP_VEL, OP_JV, OP_DELTA, OP_SUM, OP_CLAMP, OP_DIFF,
    OP_NM1, OP_NM2, OP_NMD1, OP_NMD2, OP_S1, OP_S2
  } op_e;

  typedef enum logic [1:0] {
    OUT_LOAD, OUT_READ, OUT_SOLVE
  } out_sel_e;

  typedef struct packed {
    logic     cap;
    logic     rsel_b;
    logic     lat1;
    logic     lat2;
    op_e      op;
    logic [3:0] idx;
    logic     wr_load;
    logic     wr_a;
    logic     wr_b;
    logic     div_start;
    logic     out_ld;
    out_sel_e out_sel;
  } crs_cmd_t;

  typedef struct packed {
    logic jac_zero;
    logic div_busy;
  } crs_sts_t;

endpackage

// File: rtl/core/crs_ctrl.sv
// Controller of the constraint row impulse solver: sequences body reads,
// the shared multiplier schedule, write-back, division and result transfer. Uses crs_pkg.
module crs_ctrl import crs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] func_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output crs_cmd_t   cmd_o,
  input  crs_sts_t   sts_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_WRL, S_RDA, S_RDB, S_LATB, S_MUL, S_WRA, S_WRB,
    S_DIV, S_DIVW, S_FIN, S_OUT
  } state_e;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(47);
  localparam logic [STEP_W-1:0] STEP_DOT  = STEP_W'(16);
  localparam logic [STEP_W-1:0] STEP_UPD  = STEP_W'(24);

  state_e            state_q;
  logic [STEP_W-1:0] step_q;
  logic [1:0]        func_q;
  logic              out_valid_q;
  logic [STEP_W-1:0] rel;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign rel         = step_q - STEP_UPD;

  // Decode commands from state and schedule step
  always_comb begin
    cmd_o         = '0;
    cmd_o.op      = OP_NONE;
    cmd_o.out_sel = OUT_SOLVE;
    unique case (state_q)
      S_IDLE: cmd_o.cap = in_valid_i;
      S_WRL:  cmd_o.wr_load = 1'b1;
      S_RDA:  cmd_o.rsel_b = 1'b0;
      S_RDB: begin
        cmd_o.rsel_b = 1'b1;
        cmd_o.lat1   = 1'b1;
      end
      S_LATB: cmd_o.lat2 = 1'b1;
      S_MUL: begin
        if (step_q < STEP_DOT) begin
          cmd_o.idx = step_q[3:0];
          cmd_o.op  = (step_q[1:0] == 2'd3) ? OP_NONE : OP_DOT;
        end else if (step_q < STEP_UPD) begin
          unique case (step_q[2:0])
            3'd0: cmd_o.op = OP_APC;
            3'd1: cmd_o.op = OP_VEL;
            3'd2: cmd_o.op = OP_JV;
            3'd3: cmd_o.op = OP_NONE;
            3'd4: cmd_o.op = OP_DELTA;
            3'd5: cmd_o.op = OP_SUM;
            3'd6: cmd_o.op = OP_CLAMP;
            default: cmd_o.op = OP_DIFF;
          endcase
        end else begin
          cmd_o.idx = {2'b00, rel[4:3]};
          unique case (rel[2:0])
            3'd0: cmd_o.op = OP_NM1;
            3'd1: cmd_o.op = OP_NM2;
            3'd2: cmd_o.op = OP_NMD1;
            3'd3: cmd_o.op = OP_NMD2;
            3'd4: cmd_o.op = OP_S1;
            3'd5: cmd_o.op = OP_S2;
            default: cmd_o.op = OP_NONE;
          endcase
        end
      end
      S_WRA:  cmd_o.wr_a = 1'b1;
      S_WRB:  cmd_o.wr_b = 1'b1;
      S_DIV:  cmd_o.div_start = !sts_i.jac_zero;
      S_DIVW: cmd_o.op = OP_NONE;
      S_FIN: begin
        cmd_o.out_ld = 1'b1;
        if (func_q == FUNC_LOAD) begin
          cmd_o.out_sel = OUT_LOAD;
        end else if (func_q == FUNC_READ) begin
          cmd_o.out_sel = OUT_READ;
        end else begin
          cmd_o.out_sel = OUT_SOLVE;
        end
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

  // Hold state, step counter and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      func_q      <= FUNC_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            func_q  <= func_i;
            state_q <= (func_i == FUNC_LOAD) ? S_WRL : S_RDA;
          end
        end
        S_WRL: state_q <= S_FIN;
        S_RDA: state_q <= S_RDB;
        S_RDB: state_q <= (func_q == FUNC_READ) ? S_FIN : S_LATB;
        S_LATB: begin
          step_q  <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          if (step_q == STEP_LAST) begin
            state_q <= S_WRA;
          end else begin
            step_q <= step_q + STEP_W'(1);
          end
        end
        S_WRA: state_q <= S_WRB;
        S_WRB: state_q <= S_DIV;
        S_DIV: state_q <= sts_i.jac_zero ? S_FIN : S_DIVW;
        S_DIVW: begin
          if (!sts_i.div_busy) state_q <= S_FIN;
        end
        S_FIN: begin
          out_valid_q <= 1'b1;
          state_q     <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/crs_dp.sv
// Datapath of the constraint row impulse solver: body tables, shared
// multiplier, saturating arithmetic, bit-serial divider, result registers. Uses crs_pkg.
module crs_dp import crs_pkg::*; #(
  parameter int unsigned BODY_COUNT = BODY_COUNT_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  crs_cmd_t                 cmd_i,
  output crs_sts_t                 sts_o,
  input  logic [1:0]               func_i,
  input  logic [IDX_RAW_W-1:0]     first_body_i,
  input  logic [IDX_RAW_W-1:0]     second_body_i,
  input  logic [VEC_W-1:0]         normal_first_i,
  input  logic [VEC_W-1:0]         normal_second_i,
  input  logic [VEC_W-1:0]         lever_first_i,
  input  logic [VEC_W-1:0]         lever_second_i,
  input  logic [VEC_W-1:0]         spin_first_i,
  input  logic [VEC_W-1:0]         spin_second_i,
  input  logic [63:0]              bias_and_softness_i,
  input  logic [63:0]              gain_and_impulse_i,
  input  logic [63:0]              limits_i,
  output logic signed [SCL_W-1:0]  new_impulse_o,
  output logic signed [SCL_W-1:0]  row_change_o,
  output logic [VEC_W-1:0]         linear_out_o,
  output logic [VEC_W-1:0]         angular_out_o,
  output logic [VEC_W-1:0]         mass_out_o,
  output logic [1:0]               status_o
);

  localparam int unsigned IDXW  = (BODY_COUNT > 1) ? $clog2(BODY_COUNT) : 1;
  localparam int unsigned RAW_N = 1 << IDX_RAW_W;
  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;
  localparam logic signed [63:0] C21_MAX = 64'sd1048575;
  localparam logic signed [63:0] C21_MIN = -64'sd1048576;

  function automatic logic [SCL_W:0] sat32(input logic signed [63:0] x);
    if (x > S32_MAX) return {1'b1, S32_MAX[SCL_W-1:0]};
    if (x < S32_MIN) return {1'b1, S32_MIN[SCL_W-1:0]};
    return {1'b0, x[SCL_W-1:0]};
  endfunction

  function automatic logic [COMP_W:0] sat21(input logic signed [63:0] x);
    if (x > C21_MAX) return {1'b1, C21_MAX[COMP_W-1:0]};
    if (x < C21_MIN) return {1'b1, C21_MIN[COMP_W-1:0]};
    return {1'b0, x[COMP_W-1:0]};
  endfunction

  // Index reduction table
  logic [IDXW-1:0] idx_tab [RAW_N];
  for (genvar g = 0; g < RAW_N; g++) begin : g_mod
    localparam int unsigned M = g % BODY_COUNT;
    assign idx_tab[g] = IDXW'(M);
  end

  // Captured item
  logic [1:0]              func_q;
  logic [IDXW-1:0]         ia_q, ib_q;
  logic [VEC_W-1:0]        n1w_q, n2w_q, r1w_q, r2w_q, s1w_q, s2w_q;
  logic signed [SCL_W-1:0] rhs_q, cfm_q, jac_q, ap_q, lo_q, hi_q;

  // Body words
  logic [VEC_W-1:0] lin_rd_q, ang_rd_q, mass_rd_q;
  logic [VEC_W-1:0] lin1_q, ang1_q, mass1_q, lin2_q, ang2_q, mass2_q;

  logic signed [COMP_W-1:0] n1 [3], n2 [3], r1 [3], r2 [3], s1 [3], s2 [3];
  logic signed [COMP_W-1:0] v1 [3], w1 [3], m1 [3], v2 [3], w2 [3], m2 [3];
  logic signed [COMP_W-1:0] nv1_q [3], nv2_q [3], nw1_q [3], nw2_q [3];

  // Arithmetic registers
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [SCL_W-1:0]  vel_q, delta_q, sum_q, x_q;
  logic signed [47:0]       apc_q, jv_q;
  logic signed [SCL_W:0]    d_q;
  logic signed [29:0]       nm1_q, nm2_q;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  op_e                      op_p_q;
  logic [1:0]               idx_p_q;
  logic                     sat_q;

  // Divider
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [DIV_W-1:0]     quo_q;
  logic [SCL_W-1:0]     rem_q, den_q;
  logic [SCL_W:0]       trial;
  logic                 ge;
  logic [SCL_W:0]       d_mag;
  logic [SCL_W-1:0]     jac_mag;
  logic signed [DIV_W:0] quo_s;
  logic [SCL_W:0]       row_sat;

  logic [1:0]              c;
  logic [1:0]              cp;
  logic [IDXW-1:0]         raddr, waddr;
  logic                    we_body;
  logic [VEC_W-1:0]        lin_wd, ang_wd;
  logic [SCL_W:0]          vel_s, delta_s, sum_s;
  logic signed [SCL_W-1:0] clamp_v;
  logic signed [63:0]      upd_sum;
  logic [COMP_W:0]         upd_s;
  logic                    upd_en;
  logic                    sat_set;

  logic [VEC_W-1:0] lin_mem  [BODY_COUNT];
  logic [VEC_W-1:0] ang_mem  [BODY_COUNT];
  logic [VEC_W-1:0] mass_mem [BODY_COUNT];

  // Unpack vectors
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n1[k] = n1w_q[k*COMP_W +: COMP_W];
      n2[k] = n2w_q[k*COMP_W +: COMP_W];
      r1[k] = r1w_q[k*COMP_W +: COMP_W];
      r2[k] = r2w_q[k*COMP_W +: COMP_W];
      s1[k] = s1w_q[k*COMP_W +: COMP_W];
      s2[k] = s2w_q[k*COMP_W +: COMP_W];
      v1[k] = lin1_q[k*COMP_W +: COMP_W];
      w1[k] = ang1_q[k*COMP_W +: COMP_W];
      m1[k] = mass1_q[k*COMP_W +: COMP_W];
      v2[k] = lin2_q[k*COMP_W +: COMP_W];
      w2[k] = ang2_q[k*COMP_W +: COMP_W];
      m2[k] = mass2_q[k*COMP_W +: COMP_W];
    end
  end

  // Body table access
  assign raddr   = cmd_i.rsel_b ? ib_q : ia_q;
  assign waddr   = cmd_i.wr_b ? ib_q : ia_q;
  assign we_body = cmd_i.wr_load | cmd_i.wr_a | cmd_i.wr_b;

  always_comb begin
    if (cmd_i.wr_load) begin
      lin_wd = n1w_q;
      ang_wd = n2w_q;
    end else if (cmd_i.wr_b) begin
      lin_wd = {nv2_q[2], nv2_q[1], nv2_q[0]};
      ang_wd = {nw2_q[2], nw2_q[1], nw2_q[0]};
    end else begin
      lin_wd = {nv1_q[2], nv1_q[1], nv1_q[0]};
      ang_wd = {nw1_q[2], nw1_q[1], nw1_q[0]};
    end
  end

  always_ff @(posedge clk_i) begin
    lin_rd_q  <= lin_mem[raddr];
    ang_rd_q  <= ang_mem[raddr];
    mass_rd_q <= mass_mem[raddr];
    if (we_body) begin
      lin_mem[waddr] <= lin_wd;
      ang_mem[waddr] <= ang_wd;
    end
    if (cmd_i.wr_load) mass_mem[waddr] <= r1w_q;
  end

  // Select multiplier operands
  assign c = cmd_i.idx[1:0];
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_DOT: begin
        unique case (cmd_i.idx[3:2])
          2'd0: begin mul_a = MUL_W'(n1[c]); mul_b = MUL_W'(v1[c]); end
          2'd1: begin mul_a = MUL_W'(r1[c]); mul_b = MUL_W'(w1[c]); end
          2'd2: begin mul_a = MUL_W'(n2[c]); mul_b = MUL_W'(v2[c]); end
          default: begin mul_a = MUL_W'(r2[c]); mul_b = MUL_W'(w2[c]); end
        endcase
      end
      OP_APC:  begin mul_a = MUL_W'(ap_q);   mul_b = MUL_W'(cfm_q); end
      OP_JV:   begin mul_a = MUL_W'(jac_q);  mul_b = MUL_W'(vel_q); end
      OP_NM1:  begin mul_a = MUL_W'(n1[c]);  mul_b = MUL_W'(m1[c]); end
      OP_NM2:  begin mul_a = MUL_W'(n2[c]);  mul_b = MUL_W'(m2[c]); end
      OP_NMD1: begin mul_a = MUL_W'(nm1_q);  mul_b = d_q; end
      OP_NMD2: begin mul_a = MUL_W'(nm2_q);  mul_b = d_q; end
      OP_S1:   begin mul_a = MUL_W'(s1[c]);  mul_b = d_q; end
      OP_S2:   begin mul_a = MUL_W'(s2[c]);  mul_b = d_q; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Scalar steps
  assign vel_s   = sat32(64'(acc_q >>> 8));
  assign delta_s = sat32(64'(rhs_q) - 64'(apc_q) - 64'(jv_q));
  assign sum_s   = sat32(64'(ap_q) + 64'(delta_q));

  always_comb begin
    clamp_v = (sum_q < hi_q) ? sum_q : hi_q;
    clamp_v = (clamp_v > lo_q) ? clamp_v : lo_q;
    if (func_q != FUNC_BOTH) clamp_v = (sum_q > lo_q) ? sum_q : lo_q;
  end

  // Velocity component update from the registered product
  assign cp = idx_p_q;
  always_comb begin
    upd_en = 1'b1;
    unique case (op_p_q)
      OP_NMD1: upd_sum = 64'(v1[cp]) + 64'($signed(prod_q[62:16]));
      OP_NMD2: upd_sum = 64'(v2[cp]) + 64'($signed(prod_q[62:16]));
      OP_S1:   upd_sum = 64'(w1[cp]) + 64'($signed(prod_q[53:16]));
      OP_S2:   upd_sum = 64'(w2[cp]) + 64'($signed(prod_q[53:16]));
      default: begin
        upd_sum = '0;
        upd_en  = 1'b0;
      end
    endcase
    upd_s = sat21(upd_sum);
  end

  always_comb begin
    sat_set = upd_en & upd_s[COMP_W];
    unique case (cmd_i.op)
      OP_VEL:   sat_set = sat_set | vel_s[SCL_W];
      OP_DELTA: sat_set = sat_set | delta_s[SCL_W];
      OP_SUM:   sat_set = sat_set | sum_s[SCL_W];
      default:  sat_set = sat_set;
    endcase
  end

  // Divider step and final quotient
  assign trial   = {rem_q, quo_q[DIV_W-1]};
  assign ge      = (trial >= {1'b0, den_q});
  assign d_mag   = d_q[SCL_W] ? (SCL_W+1)'(-d_q) : (SCL_W+1)'(d_q);
  assign jac_mag = jac_q[SCL_W-1] ? SCL_W'(-jac_q) : SCL_W'(jac_q);
  assign quo_s   = (d_q[SCL_W] ^ jac_q[SCL_W-1]) ? -$signed({1'b0, quo_q})
                                                 : $signed({1'b0, quo_q});
  assign row_sat = sat32(64'(quo_s));

  assign sts_o.jac_zero = (jac_q == '0);
  assign sts_o.div_busy = (div_cnt_q != '0);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_p_q    <= OP_NONE;
      idx_p_q   <= '0;
      sat_q     <= 1'b0;
      div_cnt_q <= '0;
    end else begin
      op_p_q  <= cmd_i.op;
      idx_p_q <= cmd_i.idx[1:0];
      if (cmd_i.cap) begin
        sat_q <= 1'b0;
      end else if (sat_set) begin
        sat_q <= 1'b1;
      end
      if (cmd_i.div_start) begin
        div_cnt_q <= DIV_CNT_W'(DIV_W);
      end else if (div_cnt_q != '0) begin
        div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.cap) begin
      func_q <= func_i;
      ia_q   <= idx_tab[first_body_i];
      ib_q   <= idx_tab[second_body_i];
      n1w_q  <= normal_first_i;
      n2w_q  <= normal_second_i;
      r1w_q  <= lever_first_i;
      r2w_q  <= lever_second_i;
      s1w_q  <= spin_first_i;
      s2w_q  <= spin_second_i;
      rhs_q  <= bias_and_softness_i[63:32];
      cfm_q  <= bias_and_softness_i[31:0];
      jac_q  <= gain_and_impulse_i[63:32];
      ap_q   <= gain_and_impulse_i[31:0];
      lo_q   <= limits_i[63:32];
      hi_q   <= limits_i[31:0];
      acc_q  <= '0;
    end
    if (cmd_i.lat1) begin
      lin1_q  <= lin_rd_q;
      ang1_q  <= ang_rd_q;
      mass1_q <= mass_rd_q;
    end
    if (cmd_i.lat2) begin
      lin2_q  <= lin_rd_q;
      ang2_q  <= ang_rd_q;
      mass2_q <= mass_rd_q;
    end

    // Steps issued this cycle
    unique case (cmd_i.op)
      OP_VEL:   vel_q   <= vel_s[SCL_W-1:0];
      OP_DELTA: delta_q <= delta_s[SCL_W-1:0];
      OP_SUM:   sum_q   <= sum_s[SCL_W-1:0];
      OP_CLAMP: x_q     <= clamp_v;
      OP_DIFF:  d_q     <= (SCL_W+1)'(x_q) - (SCL_W+1)'(ap_q);
      default: ;
    endcase

    // Consume the product issued last cycle
    unique case (op_p_q)
      OP_DOT:  acc_q <= acc_q + $signed(prod_q[ACC_W-1:0]);
      OP_APC:  apc_q <= $signed(prod_q[63:16]);
      OP_JV:   jv_q  <= $signed(prod_q[63:16]);
      OP_NM1:  nm1_q <= $signed(prod_q[41:12]);
      OP_NM2:  nm2_q <= $signed(prod_q[41:12]);
      OP_NMD1: nv1_q[cp] <= upd_s[COMP_W-1:0];
      OP_NMD2: nv2_q[cp] <= upd_s[COMP_W-1:0];
      OP_S1:   nw1_q[cp] <= upd_s[COMP_W-1:0];
      OP_S2:   nw2_q[cp] <= upd_s[COMP_W-1:0];
      default: ;
    endcase

    // Restoring division, one quotient bit per cycle
    if (cmd_i.div_start) begin
      quo_q <= {d_mag, 16'd0};
      rem_q <= '0;
      den_q <= jac_mag;
    end else if (div_cnt_q != '0) begin
      quo_q <= {quo_q[DIV_W-2:0], ge};
      rem_q <= ge ? SCL_W'(trial - {1'b0, den_q}) : trial[SCL_W-1:0];
    end

    // Load result
    if (cmd_i.out_ld) begin
      new_impulse_o <= '0;
      row_change_o  <= '0;
      linear_out_o  <= '0;
      angular_out_o <= '0;
      mass_out_o    <= '0;
      status_o      <= ST_OK;
      unique case (cmd_i.out_sel)
        OUT_READ: begin
          linear_out_o  <= lin1_q;
          angular_out_o <= ang1_q;
          mass_out_o    <= mass1_q;
        end
        OUT_SOLVE: begin
          new_impulse_o <= x_q;
          if (jac_q == '0) begin
            status_o <= ST_JAC_ZERO;
          end else begin
            row_change_o <= row_sat[SCL_W-1:0];
            status_o     <= (sat_q | row_sat[SCL_W]) ? ST_SAT : ST_OK;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/constraint_row_impulse_solver.sv
// Top level of the constraint row impulse solver: controller plus datapath.
// Depends on crs_pkg, crs_ctrl and crs_dp.

// One item is handled at a time. A solve runs a schedule on the single shared
// 33x33 multiplier, which also carries the scalar steps and velocity updates,
// then two body write-backs through the one table write port, then a
// bit-serial divider for the row change, which is skipped when the inverse
// jacobian diagonal is zero. The next input is taken once the result has been
// transferred.
// Reading a body that was never loaded returns undefined data.
module constraint_row_impulse_solver import crs_pkg::*; #(
  parameter int unsigned BODY_COUNT = BODY_COUNT_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              func_i,
  input  logic [IDX_RAW_W-1:0]    first_body_i,
  input  logic [IDX_RAW_W-1:0]    second_body_i,
  input  logic [VEC_W-1:0]        normal_first_i,
  input  logic [VEC_W-1:0]        normal_second_i,
  input  logic [VEC_W-1:0]        lever_first_i,
  input  logic [VEC_W-1:0]        lever_second_i,
  input  logic [VEC_W-1:0]        spin_first_i,
  input  logic [VEC_W-1:0]        spin_second_i,
  input  logic [63:0]             bias_and_softness_i,
  input  logic [63:0]             gain_and_impulse_i,
  input  logic [63:0]             limits_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [SCL_W-1:0] new_impulse_o,
  output logic signed [SCL_W-1:0] row_change_o,
  output logic [VEC_W-1:0]        linear_out_o,
  output logic [VEC_W-1:0]        angular_out_o,
  output logic [VEC_W-1:0]        mass_out_o,
  output logic [1:0]              status_o
);

  crs_cmd_t cmd;
  crs_sts_t sts;

  crs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  crs_dp #(
    .BODY_COUNT (BODY_COUNT)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .func_i              (func_i),
    .first_body_i        (first_body_i),
    .second_body_i       (second_body_i),
    .normal_first_i      (normal_first_i),
    .normal_second_i     (normal_second_i),
    .lever_first_i       (lever_first_i),
    .lever_second_i      (lever_second_i),
    .spin_first_i        (spin_first_i),
    .spin_second_i       (spin_second_i),
    .bias_and_softness_i (bias_and_softness_i),
    .gain_and_impulse_i  (gain_and_impulse_i),
    .limits_i            (limits_i),
    .new_impulse_o       (new_impulse_o),
    .row_change_o        (row_change_o),
    .linear_out_o        (linear_out_o),
    .angular_out_o       (angular_out_o),
    .mass_out_o          (mass_out_o),
    .status_o            (status_o)
  );

`ifndef ASSERT_OFF
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while a result is pending");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready right after a transfer");

  a_writeback_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_a |=> cmd.wr_b)
    else $error("second body write-back missing");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_JAC_ZERO || status_o == ST_SAT))
    else $error("invalid status code");
`endif

endmodule

// File: verif/constraint_row_impulse_solver_tb.sv
// Testbench for the constraint row impulse solver: random and directed body loads,
// reads and row solves checked against an in-bench fixed-point predictor.
// Depends on crs_pkg and the constraint_row_impulse_solver top level.
`timescale 1ns / 1ps

module constraint_row_impulse_solver_tb;
  import crs_pkg::*;

  typedef struct {
    logic [1:0]  func;
    logic [5:0]  first_body;
    logic [5:0]  second_body;
    logic [62:0] normal_first;
    logic [62:0] normal_second;
    logic [62:0] lever_first;
    logic [62:0] lever_second;
    logic [62:0] spin_first;
    logic [62:0] spin_second;
    logic [63:0] bias_and_softness;
    logic [63:0] gain_and_impulse;
    logic [63:0] limits;
  } row_item_t;

  typedef struct {
    logic [31:0] new_impulse;
    logic [31:0] row_change;
    logic [62:0] linear_out;
    logic [62:0] angular_out;
    logic [62:0] mass_out;
    logic [1:0]  status;
  } row_result_t;

  // Body table mirror plus the queue of predicted results
  class impulse_scoreboard;
    logic [62:0] lin_tab[64];
    logic [62:0] ang_tab[64];
    logic [62:0] mass_tab[64];
    row_result_t pending_q[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function longint comp(logic [62:0] v, int i);
      logic signed [20:0] c;
      c = v[21*i +: 21];
      return longint'(c);
    endfunction

    function longint clip(longint x, longint lo, longint hi, inout bit flag);
      if (x > hi) begin
        flag = 1;
        return hi;
      end
      if (x < lo) begin
        flag = 1;
        return lo;
      end
      return x;
    endfunction

    function longint half(logic [63:0] w, bit upper);
      logic signed [31:0] h;
      h = upper ? w[63:32] : w[31:0];
      return longint'(h);
    endfunction

    // Predict the result of one transfer and update the table mirror
    function void note_input(row_item_t it);
      row_result_t r;
      longint dsum, vel, rhs, cfm, jac, ap, lo, hi, delta, tot, x, d, row;
      longint v, w;
      logic [62:0] nl1, nl2, na1, na2;
      bit sat;
      int a, b;
      a = it.first_body;
      b = it.second_body;
      r = '{default: '0};
      sat = 0;
      if (it.func == FUNC_LOAD) begin
        lin_tab[a] = it.normal_first;
        ang_tab[a] = it.normal_second;
        mass_tab[a] = it.lever_first;
      end else if (it.func == FUNC_READ) begin
        r.linear_out = lin_tab[a];
        r.angular_out = ang_tab[a];
        r.mass_out = mass_tab[a];
      end else begin
        dsum = 0;
        for (int i = 0; i < 3; i++) begin
          dsum += comp(it.normal_first, i) * comp(lin_tab[a], i);
          dsum += comp(it.lever_first, i) * comp(ang_tab[a], i);
          dsum += comp(it.normal_second, i) * comp(lin_tab[b], i);
          dsum += comp(it.lever_second, i) * comp(ang_tab[b], i);
        end
        vel = clip(dsum >>> 8, -64'sd2147483648, 64'sd2147483647, sat);
        rhs = half(it.bias_and_softness, 1);
        cfm = half(it.bias_and_softness, 0);
        jac = half(it.gain_and_impulse, 1);
        ap = half(it.gain_and_impulse, 0);
        lo = half(it.limits, 1);
        hi = half(it.limits, 0);
        delta = rhs - ((ap * cfm) >>> 16) - ((jac * vel) >>> 16);
        delta = clip(delta, -64'sd2147483648, 64'sd2147483647, sat);
        tot = clip(ap + delta, -64'sd2147483648, 64'sd2147483647, sat);
        if (it.func == FUNC_BOTH) begin
          x = (tot < hi) ? tot : hi;
          x = (x > lo) ? x : lo;
        end else begin
          x = (tot > lo) ? tot : lo;
        end
        d = x - ap;
        // Both bodies update from the old values
        for (int i = 0; i < 3; i++) begin
          v = comp(lin_tab[a], i) +
              ((((comp(it.normal_first, i) * comp(mass_tab[a], i)) >>> 12) * d) >>> 16);
          nl1[21*i +: 21] = 21'(clip(v, -1048576, 1048575, sat));
          v = comp(lin_tab[b], i) +
              ((((comp(it.normal_second, i) * comp(mass_tab[b], i)) >>> 12) * d) >>> 16);
          nl2[21*i +: 21] = 21'(clip(v, -1048576, 1048575, sat));
          w = comp(ang_tab[a], i) + ((comp(it.spin_first, i) * d) >>> 16);
          na1[21*i +: 21] = 21'(clip(w, -1048576, 1048575, sat));
          w = comp(ang_tab[b], i) + ((comp(it.spin_second, i) * d) >>> 16);
          na2[21*i +: 21] = 21'(clip(w, -1048576, 1048575, sat));
        end
        lin_tab[a] = nl1;
        ang_tab[a] = na1;
        lin_tab[b] = nl2;
        ang_tab[b] = na2;
        if (jac == 0) begin
          row = 0;
          r.status = ST_JAC_ZERO;
        end else begin
          row = clip((d * 65536) / jac, -64'sd2147483648, 64'sd2147483647, sat);
          r.status = sat ? ST_SAT : ST_OK;
        end
        r.new_impulse = x[31:0];
        r.row_change = row[31:0];
      end
      pending_q.push_back(r);
    endfunction

    // Compare one result transfer with the oldest prediction
    function void check_result(row_result_t got);
      row_result_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.new_impulse !== e.new_impulse) begin
        $error("new_impulse exp %h got %h", e.new_impulse, got.new_impulse);
        errors++;
      end
      if (got.row_change !== e.row_change) begin
        $error("row_change exp %h got %h", e.row_change, got.row_change);
        errors++;
      end
      if (got.linear_out !== e.linear_out) begin
        $error("linear_out exp %h got %h", e.linear_out, got.linear_out);
        errors++;
      end
      if (got.angular_out !== e.angular_out) begin
        $error("angular_out exp %h got %h", e.angular_out, got.angular_out);
        errors++;
      end
      if (got.mass_out !== e.mass_out) begin
        $error("mass_out exp %h got %h", e.mass_out, got.mass_out);
        errors++;
      end
      if (got.status !== e.status) begin
        $error("status exp %h got %h", e.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [1:0]  func_i;
  logic [5:0]  first_body_i, second_body_i;
  logic [62:0] normal_first_i, normal_second_i, lever_first_i, lever_second_i;
  logic [62:0] spin_first_i, spin_second_i;
  logic [63:0] bias_and_softness_i, gain_and_impulse_i, limits_i;
  logic signed [31:0] new_impulse_o, row_change_o;
  logic [62:0] linear_out_o, angular_out_o, mass_out_o;
  logic [1:0]  status_o;

  impulse_scoreboard sb;
  bit loaded[64];
  bit quiet;
  bit hold_req;
  longint cycles;

  constraint_row_impulse_solver dut (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 1000000) begin
        $display("FAIL constraint_row_impulse_solver");
        $finish;
      end
    end
  end

  // Result side: random stall bursts, one long hold-off on request
  initial begin
    int stall_cnt;
    row_result_t got;
    stall_cnt = 0;
    out_ready_i = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got.new_impulse = new_impulse_o;
        got.row_change = row_change_o;
        got.linear_out = linear_out_o;
        got.angular_out = angular_out_o;
        got.mass_out = mass_out_o;
        got.status = status_o;
        sb.check_result(got);
      end
      if (hold_req) begin
        hold_req = 0;
        stall_cnt = 400;
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        out_ready_i <= 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_cnt = $urandom_range(0, 10);
        out_ready_i <= 0;
      end else begin
        out_ready_i <= 1;
      end
    end
  end

  // Send one item, holding valid until the transfer
  task automatic send_item(row_item_t it);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    func_i <= it.func;
    first_body_i <= it.first_body;
    second_body_i <= it.second_body;
    normal_first_i <= it.normal_first;
    normal_second_i <= it.normal_second;
    lever_first_i <= it.lever_first;
    lever_second_i <= it.lever_second;
    spin_first_i <= it.spin_first;
    spin_second_i <= it.spin_second;
    bias_and_softness_i <= it.bias_and_softness;
    gain_and_impulse_i <= it.gain_and_impulse;
    limits_i <= it.limits;
    in_valid_i <= 1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(it);
    if (it.func == FUNC_LOAD) loaded[it.first_body] = 1;
  endtask

  // Drop valid and wait until every expected result has come
  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [62:0] rand_vec(bit narrow);
    logic [62:0] v;
    for (int i = 0; i < 3; i++) begin
      if (narrow) v[21*i +: 21] = 21'($signed($urandom_range(0, 8191)) - 4096);
      else v[21*i +: 21] = 21'($urandom);
    end
    return v;
  endfunction

  function automatic logic [31:0] rand_scalar(bit narrow);
    if (narrow) return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    return $urandom;
  endfunction

  function automatic row_item_t rand_item();
    row_item_t it;
    bit nr;
    nr = $urandom_range(0, 3) != 0;
    it.func = 2'($urandom);
    it.first_body = 6'($urandom);
    it.second_body = ($urandom_range(0, 9) == 0) ? it.first_body : 6'($urandom);
    it.normal_first = rand_vec(nr);
    it.normal_second = rand_vec(nr);
    it.lever_first = rand_vec(nr);
    it.lever_second = rand_vec(nr);
    it.spin_first = rand_vec(nr);
    it.spin_second = rand_vec(nr);
    it.bias_and_softness = {rand_scalar(nr), rand_scalar(nr)};
    it.gain_and_impulse = {($urandom_range(0, 15) == 0) ? 32'd0 : rand_scalar(nr),
                           rand_scalar(nr)};
    it.limits = {rand_scalar(nr), rand_scalar(nr)};
    if (it.func != FUNC_LOAD && $urandom_range(0, 1) == 0) begin
      // Keep most limits ordered so rows land inside the window
      it.limits = {32'hfff0_0000, 32'h0010_0000};
    end
    // Never touch a body that was not loaded
    if (!loaded[it.first_body] ||
        ((it.func == FUNC_BOTH || it.func == FUNC_LOWER) && !loaded[it.second_body]))
      it.func = FUNC_LOAD;
    return it;
  endfunction

  initial begin
    row_item_t it;
    sb = new();
    quiet = 0;
    hold_req = 0;
    rst_ni = 0;
    in_valid_i = 0;
    func_i = FUNC_LOAD;
    first_body_i = '0;
    second_body_i = '0;
    normal_first_i = '0;
    normal_second_i = '0;
    lever_first_i = '0;
    lever_second_i = '0;
    spin_first_i = '0;
    spin_second_i = '0;
    bias_and_softness_i = '0;
    gain_and_impulse_i = '0;
    limits_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: extreme loads and reads at both ends of the table, plus one body in the middle
    it = rand_item();
    it.func = FUNC_LOAD;
    it.first_body = 6'd0;
    it.normal_first = '1;
    it.normal_second = {3{21'h0fffff}};
    it.lever_first = {3{21'h100000}};
    send_item(it);
    it.first_body = 6'd63;
    it.normal_first = {3{21'h0fffff}};
    it.normal_second = {3{21'h100000}};
    it.lever_first = {3{21'h0fffff}};
    send_item(it);
    it.first_body = 6'd5;
    it.normal_first = {3{21'h000100}};
    it.normal_second = {3{21'h1fff00}};
    it.lever_first = {3{21'h001000}};
    send_item(it);
    it.func = FUNC_READ;
    send_item(it);
    it.first_body = 6'd0;
    send_item(it);
    it.first_body = 6'd63;
    send_item(it);

    // Directed solves: saturation, zero gain, crossed limits, same body; then reads back
    it.func = FUNC_BOTH;
    it.first_body = 6'd0;
    it.second_body = 6'd63;
    it.normal_first = {3{21'h0fffff}};
    it.normal_second = {3{21'h100000}};
    it.lever_first = '1;
    it.lever_second = {3{21'h0fffff}};
    it.spin_first = {3{21'h0fffff}};
    it.spin_second = {3{21'h100000}};
    it.bias_and_softness = {32'h7fffffff, 32'h80000000};
    it.gain_and_impulse = {32'h7fffffff, 32'h80000000};
    it.limits = {32'h80000000, 32'h7fffffff};
    send_item(it);
    it.gain_and_impulse = {32'd0, 32'h0001_0000};
    send_item(it);
    it.gain_and_impulse = {32'h0001_0000, 32'h0000_8000};
    it.limits = {32'h0004_0000, 32'hfffc_0000};
    send_item(it);
    it.func = FUNC_LOWER;
    it.first_body = 6'd5;
    it.second_body = 6'd5;
    it.normal_first = {3{21'h000800}};
    it.normal_second = {3{21'h1ff800}};
    it.lever_first = {3{21'h000400}};
    it.lever_second = {3{21'h000200}};
    it.spin_first = {3{21'h000100}};
    it.spin_second = {3{21'h1fff00}};
    it.bias_and_softness = {32'h0002_0000, 32'h0000_1000};
    it.gain_and_impulse = {32'hffff_0000, 32'h0000_4000};
    it.limits = {32'h0000_0000, 32'h0001_0000};
    send_item(it);
    it.func = FUNC_READ;
    send_item(it);
    it.first_body = 6'd0;
    send_item(it);

    // Random part with one long hold-off, one full pause and a quiet tail without random gaps or stalls
    for (int n = 0; n < 400; n++) begin
      if (n == 150) hold_req = 1;
      if (n == 250) drain();
      if (n == 330) quiet = 1;
      send_item(rand_item());
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("PASS constraint_row_impulse_solver");
    end else begin
      $display("FAIL constraint_row_impulse_solver");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/crs_pkg.sv
rtl/core/crs_ctrl.sv
rtl/core/crs_dp.sv
rtl/core/constraint_row_impulse_solver.sv
verif/constraint_row_impulse_solver_tb.sv
